// File: rtl/mqt_pkg.sv
// ----------------------------------------------------------------------------
// mqt_pkg
// Shared types and constants of the message queue with timer table.
// ----------------------------------------------------------------------------
`default_nettype none

package mqt_pkg;

  localparam int MSG_DEPTH   = 16;
  localparam int TIMER_DEPTH = 16;

  localparam int MAW = $clog2(MSG_DEPTH);
  localparam int MCW = $clog2(MSG_DEPTH + 1);
  localparam int TAW = $clog2(TIMER_DEPTH);
  localparam int TCW = $clog2(TIMER_DEPTH + 1);

  localparam int TICKS_W = 62;
  localparam int EXP_W   = 63;
  localparam int PROD_W  = 46;

  localparam logic [13:0] TICKS_PER_MS = 14'd10000;
  localparam logic [31:0] CODE_QUIT    = 32'h0000_0012;
  localparam logic [31:0] CODE_TIMER   = 32'h0000_0113;

  localparam logic [2:0] OPC_POST  = 3'd0;
  localparam logic [2:0] OPC_QUIT  = 3'd1;
  localparam logic [2:0] OPC_SET   = 3'd2;
  localparam logic [2:0] OPC_KILL  = 3'd3;
  localparam logic [2:0] OPC_GET   = 3'd4;

  localparam logic [1:0] SRC_NONE   = 2'd0;
  localparam logic [1:0] SRC_POSTED = 2'd1;
  localparam logic [1:0] SRC_QUIT   = 2'd2;
  localparam logic [1:0] SRC_TIMER  = 2'd3;

  typedef enum logic [2:0] {
    OPK_POST,
    OPK_QUIT,
    OPK_SET,
    OPK_KILL,
    OPK_GET,
    OPK_NOP
  } op_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_REMOVE,
    S_MUL,
    S_ADD,
    S_INS,
    S_GET_SCAN,
    S_FIFO_RD,
    S_DONE
  } back_state_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [31:0]          window;
    logic [31:0]          msg_code;
    logic [31:0]          word_param;
    logic [31:0]          long_param;
    logic [31:0]          exit_code;
    logic [31:0]          timer_id;
    logic [31:0]          period_ms;
    logic [31:0]          timer_tag;
    logic [TICKS_W-1:0]   now_ticks;
    logic [31:0]          now_ms;
  } cmd_t;

  typedef struct packed {
    logic [31:0] window;
    logic [31:0] code;
    logic [31:0] word;
    logic [31:0] lng;
    logic [31:0] stamp;
  } posted_t;

  typedef struct packed {
    logic [31:0]      window;
    logic [31:0]      id;
    logic [31:0]      period;
    logic [31:0]      tag;
    logic [EXP_W-1:0] expiry;
  } timer_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  source;
    logic [31:0] window;
    logic [31:0] code;
    logic [31:0] word;
    logic [31:0] lng;
    logic [31:0] stamp;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/mqt_ram.sv
// ----------------------------------------------------------------------------
// mqt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mqt_front.sv
// ----------------------------------------------------------------------------
// mqt_front
// Accepts input transactions, decodes the op and queues up to two commands.
// ----------------------------------------------------------------------------
`default_nettype none

module mqt_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [2:0]              in_op,
  input  wire logic [31:0]             in_window,
  input  wire logic [31:0]             in_msg_code,
  input  wire logic [31:0]             in_word_param,
  input  wire logic [31:0]             in_long_param,
  input  wire logic [31:0]             in_exit_code,
  input  wire logic [31:0]             in_timer_id,
  input  wire logic [31:0]             in_period_ms,
  input  wire logic [31:0]             in_timer_tag,
  input  wire logic [61:0]             in_now_ticks,
  input  wire logic [31:0]             in_now_ms,
  output logic                         cmd_valid,
  input  wire logic                    cmd_ready,
  output mqt_pkg::cmd_t                cmd
);

  import mqt_pkg::*;

  cmd_t       q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;
  cmd_t       dec;

  function automatic op_kind_t classify(input logic [2:0] opc);
    op_kind_t k;
    unique case (opc)
      OPC_POST: k = OPK_POST;
      OPC_QUIT: k = OPK_QUIT;
      OPC_SET:  k = OPK_SET;
      OPC_KILL: k = OPK_KILL;
      OPC_GET:  k = OPK_GET;
      default:  k = OPK_NOP;
    endcase
    return k;
  endfunction

  assign in_ready  = (cnt_r != 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    dec.kind       = classify(in_op);
    dec.window     = in_window;
    dec.msg_code   = in_msg_code;
    dec.word_param = in_word_param;
    dec.long_param = in_long_param;
    dec.exit_code  = in_exit_code;
    dec.timer_id   = in_timer_id;
    dec.period_ms  = in_period_ms;
    dec.timer_tag  = in_timer_tag;
    dec.now_ticks  = in_now_ticks;
    dec.now_ms     = in_now_ms;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mqt_back.sv
// ----------------------------------------------------------------------------
// mqt_back
// Executes queued commands against the posted FIFO, quit flag and the
// expiry-sorted timer table; holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mqt_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire mqt_pkg::cmd_t cmd,
  output logic               out_valid,
  input  wire logic          out_ready,
  output mqt_pkg::res_t      res_out
);

  import mqt_pkg::*;

  back_state_t        state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [MAW-1:0]     fifo_head_r, fifo_head_nxt;
  logic [MCW-1:0]     fifo_cnt_r, fifo_cnt_nxt;
  logic               quit_pend_r, quit_pend_nxt;
  logic [31:0]        quit_code_r, quit_code_nxt;
  timer_t             timers_r [TIMER_DEPTH];
  timer_t             timers_nxt [TIMER_DEPTH];
  logic [TCW-1:0]     tcnt_r, tcnt_nxt;
  logic [TCW-1:0]     idx_r, idx_nxt;
  logic [TAW-1:0]     pos_r, pos_nxt;
  timer_t             new_r, new_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  res_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_r, out_nxt;

  logic               ram_we, ram_re;
  logic [MAW-1:0]     tail_addr;
  logic [MAW:0]       tail_sum;
  posted_t            ram_wdata, ram_rdata;
  timer_t             cur;
  logic               idx_lt;
  logic               out_load;

  mqt_ram #(
    .WIDTH ($bits(posted_t)),
    .DEPTH (MSG_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (fifo_head_r),
    .rdata (ram_rdata)
  );

  assign tail_sum  = {1'b0, fifo_head_r} + (MAW+1)'(fifo_cnt_r);
  assign tail_addr = (tail_sum >= (MAW+1)'(MSG_DEPTH)) ?
                     MAW'(tail_sum - (MAW+1)'(MSG_DEPTH)) : MAW'(tail_sum);

  assign cur    = timers_r[idx_r[TAW-1:0]];
  assign idx_lt = (idx_r < tcnt_r);

  assign out_valid = out_valid_r;
  assign res_out   = out_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    ram_wdata.window = cmd.window;
    ram_wdata.code   = cmd.msg_code;
    ram_wdata.word   = cmd.word_param;
    ram_wdata.lng    = cmd.long_param;
    ram_wdata.stamp  = cmd.now_ms;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    fifo_head_nxt = fifo_head_r;
    fifo_cnt_nxt  = fifo_cnt_r;
    quit_pend_nxt = quit_pend_r;
    quit_code_nxt = quit_code_r;
    timers_nxt    = timers_r;
    tcnt_nxt      = tcnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    new_nxt       = new_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    cmd_ready     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt        = cmd;
          res_nxt        = '0;
          idx_nxt        = '0;
          new_nxt.window = cmd.window;
          new_nxt.id     = cmd.timer_id;
          new_nxt.period = cmd.period_ms;
          new_nxt.tag    = cmd.timer_tag;
          new_nxt.expiry = '0;
          state_nxt      = S_DONE;
          unique case (cmd.kind)
            OPK_POST: begin
              if (fifo_cnt_r < MCW'(MSG_DEPTH)) begin
                ram_we       = 1'b1;
                fifo_cnt_nxt = fifo_cnt_r + 1'b1;
                res_nxt.ok   = 1'b1;
              end
            end
            OPK_QUIT: begin
              quit_pend_nxt = 1'b1;
              quit_code_nxt = cmd.exit_code;
              res_nxt.ok    = 1'b1;
            end
            OPK_SET, OPK_KILL: begin
              state_nxt = S_FIND;
            end
            OPK_GET: begin
              if (fifo_cnt_r != '0) begin
                ram_re    = 1'b1;
                state_nxt = S_FIFO_RD;
              end else if (quit_pend_r) begin
                quit_pend_nxt  = 1'b0;
                res_nxt.ok     = 1'b1;
                res_nxt.source = SRC_QUIT;
                res_nxt.code   = CODE_QUIT;
                res_nxt.word   = quit_code_r;
              end else begin
                state_nxt = S_GET_SCAN;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_FIND: begin
        if (idx_lt) begin
          if (cur.window == cmd_r.window && cur.id == cmd_r.timer_id) begin
            pos_nxt   = idx_r[TAW-1:0];
            state_nxt = S_REMOVE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end else if (cmd_r.kind == OPK_KILL) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end

      S_REMOVE: begin
        // close the gap left at pos
        for (int j = 0; j < TIMER_DEPTH - 1; j++) begin
          if (TAW'(j) >= pos_r) begin
            timers_nxt[j] = timers_r[j+1];
          end
        end
        tcnt_nxt = tcnt_r - 1'b1;
        if (cmd_r.kind == OPK_KILL) begin
          res_nxt.ok = 1'b1;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_MUL;
        end
      end

      S_MUL: begin
        if (tcnt_r < TCW'(TIMER_DEPTH)) begin
          prod_nxt  = new_r.period * TICKS_PER_MS;
          state_nxt = S_ADD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_ADD: begin
        new_nxt.expiry = {1'b0, cmd_r.now_ticks} + EXP_W'(prod_r);
        idx_nxt        = '0;
        state_nxt      = S_INS;
      end

      S_INS: begin
        if (idx_lt && cur.expiry < new_r.expiry) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          // open a slot at idx and drop the timer in
          for (int j = 1; j < TIMER_DEPTH; j++) begin
            if (TCW'(j) > idx_r) begin
              timers_nxt[j] = timers_r[j-1];
            end
          end
          timers_nxt[idx_r[TAW-1:0]] = new_r;
          tcnt_nxt   = tcnt_r + 1'b1;
          res_nxt.ok = 1'b1;
          if (cmd_r.kind == OPK_GET) begin
            res_nxt.source = SRC_TIMER;
            res_nxt.window = new_r.window;
            res_nxt.code   = CODE_TIMER;
            res_nxt.word   = new_r.id;
            res_nxt.lng    = new_r.tag;
            res_nxt.stamp  = cmd_r.now_ms;
          end
          state_nxt = S_DONE;
        end
      end

      S_GET_SCAN: begin
        if (!idx_lt || cur.expiry > {1'b0, cmd_r.now_ticks}) begin
          state_nxt = S_DONE;
        end else if (cmd_r.window == '0 || cur.window == cmd_r.window) begin
          new_nxt   = cur;
          pos_nxt   = idx_r[TAW-1:0];
          state_nxt = S_REMOVE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_FIFO_RD: begin
        res_nxt.ok     = 1'b1;
        res_nxt.source = SRC_POSTED;
        res_nxt.window = ram_rdata.window;
        res_nxt.code   = ram_rdata.code;
        res_nxt.word   = ram_rdata.word;
        res_nxt.lng    = ram_rdata.lng;
        res_nxt.stamp  = ram_rdata.stamp;
        fifo_head_nxt  = (fifo_head_r == MAW'(MSG_DEPTH - 1)) ? '0 : fifo_head_r + 1'b1;
        fifo_cnt_nxt   = fifo_cnt_r - 1'b1;
        state_nxt      = S_DONE;
      end

      S_DONE: begin
        if (out_load) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fifo_head_r <= '0;
      fifo_cnt_r  <= '0;
      quit_pend_r <= 1'b0;
      quit_code_r <= '0;
      tcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fifo_head_r <= fifo_head_nxt;
      fifo_cnt_r  <= fifo_cnt_nxt;
      quit_pend_r <= quit_pend_nxt;
      quit_code_r <= quit_code_nxt;
      tcnt_r      <= tcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    timers_r <= timers_nxt;
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    new_r    <= new_nxt;
    prod_r   <= prod_nxt;
    res_r    <= res_nxt;
    out_r    <= out_nxt;
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_cnt_r <= MCW'(MSG_DEPTH))
    else $error("posted fifo count beyond depth");

  a_timer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= TCW'(TIMER_DEPTH))
    else $error("timer count beyond depth");

  a_fifo_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIFO_RD) |=> (fifo_cnt_r == $past(fifo_cnt_r) - 1'b1))
    else $error("fifo read did not consume an entry");

  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (state_r == S_IDLE && out_valid_r))
    else $error("result not handed to output register");

  for (genvar g = 0; g < TIMER_DEPTH - 1; g++) begin : g_sorted
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      (TCW'(g + 1) < tcnt_r && state_r == S_IDLE) |->
        (timers_r[g].expiry <= timers_r[g+1].expiry))
      else $error("timer table out of expiry order");
  end

endmodule

`default_nettype wire

// File: rtl/message_queue_with_timer_table.sv
// ----------------------------------------------------------------------------
// message_queue_with_timer_table
// Posted-message FIFO, quit flag and expiry-sorted timer table.
// ----------------------------------------------------------------------------
// Usage: one op per input transaction (post, post_quit, set_timer,
// kill_timer, get); every op yields exactly one output transaction.
// Both channels are valid/ready. The front decodes ops into a two-entry
// command queue, so up to two transactions are taken while the back works.
// The back executes one command at a time. Post, post_quit, undefined ops
// and a get from the quit flag go straight to the result; a get from the
// fifo first reads the RAM; kill_timer searches the table and removes the
// entry; set_timer searches, removes an old entry if found, multiplies the
// period into ticks, adds the current time and inserts in expiry order; a
// get from timers scans, removes, re-arms and inserts the expired timer.
// The timer search and insertion walk the table one entry per cycle.
// The result sits in an output register; when the receiver stalls the
// back holds its next result and the command queue fills, then in_ready
// drops. Reset clears the fifo count, the quit flag and the timer count.
// ----------------------------------------------------------------------------
`default_nettype none

module message_queue_with_timer_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_op,
  input  wire logic [31:0] in_window,
  input  wire logic [31:0] in_msg_code,
  input  wire logic [31:0] in_word_param,
  input  wire logic [31:0] in_long_param,
  input  wire logic [31:0] in_exit_code,
  input  wire logic [31:0] in_timer_id,
  input  wire logic [31:0] in_period_ms,
  input  wire logic [31:0] in_timer_tag,
  input  wire logic [61:0] in_now_ticks,
  input  wire logic [31:0] in_now_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ok,
  output logic [1:0]       out_source,
  output logic [31:0]      out_window,
  output logic [31:0]      out_code,
  output logic [31:0]      out_word,
  output logic [31:0]      out_long,
  output logic [31:0]      out_time
);

  import mqt_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  mqt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_window     (in_window),
    .in_msg_code   (in_msg_code),
    .in_word_param (in_word_param),
    .in_long_param (in_long_param),
    .in_exit_code  (in_exit_code),
    .in_timer_id   (in_timer_id),
    .in_period_ms  (in_period_ms),
    .in_timer_tag  (in_timer_tag),
    .in_now_ticks  (in_now_ticks),
    .in_now_ms     (in_now_ms),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  mqt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res)
  );

  assign out_ok     = res.ok;
  assign out_source = res.source;
  assign out_window = res.window;
  assign out_code   = res.code;
  assign out_word   = res.word;
  assign out_long   = res.lng;
  assign out_time   = res.stamp;

endmodule

`default_nettype wire
